FILE: rtl/mphl_pkg.sv
// package: constants, types and helper functions for the node lookup block
package mphl_pkg;

  localparam int unsigned MaxNodes = 1024;
  localparam int unsigned IdxW = $clog2(MaxNodes);
  localparam int unsigned TotW = IdxW + 1;
  localparam int unsigned NodeW = 10;

  localparam logic [63:0] SipC0 = 64'h736f6d6570736575;
  localparam logic [63:0] SipC1 = 64'h646f72616e646f6d;
  localparam logic [63:0] SipC2 = 64'h6c7967656e657261;
  localparam logic [63:0] SipC3 = 64'h7465646279746573;
  localparam logic [63:0] AllOnes = 64'hffffffffffffffff;
  localparam logic [7:0] FinalXor = 8'hff;
  localparam int unsigned LenShift = 56;

  localparam logic [1:0] FuncName = 2'd0;
  localparam logic [1:0] FuncKey = 2'd1;
  localparam logic [1:0] FuncClear = 2'd2;

  localparam logic [1:0] KindStored = 2'd0;
  localparam logic [1:0] KindLookup = 2'd1;
  localparam logic [1:0] KindCleared = 2'd2;

  localparam logic [1:0] StatOk = 2'd0;
  localparam logic [1:0] StatEmpty = 2'd1;
  localparam logic [1:0] StatNoProbe = 2'd2;
  localparam logic [1:0] StatFull = 2'd3;

  localparam logic [1:0] CfgSeedFirst = 2'd0;
  localparam logic [1:0] CfgSeedSecond = 2'd1;
  localparam logic [1:0] CfgProbeCount = 2'd2;

  typedef logic [63:0] lane_t [4];

  typedef struct packed {
    logic [1:0] kind;
    logic [NodeW-1:0] node;
    logic [63:0] distance;
    logic [1:0] status;
  } result_t;

  function automatic logic [63:0] rotl(input logic [63:0] x, input int unsigned r);
    rotl = (x << r) | (x >> (64 - r));
  endfunction

  function automatic lane_t sip_round(input lane_t v);
    lane_t w;
    w = v;
    w[0] = w[0] + w[1];
    w[2] = w[2] + w[3];
    w[1] = rotl(w[1], 13);
    w[3] = rotl(w[3], 16);
    w[1] = w[1] ^ w[0];
    w[3] = w[3] ^ w[2];
    w[0] = rotl(w[0], 32);
    w[2] = w[2] + w[1];
    w[0] = w[0] + w[3];
    w[1] = rotl(w[1], 17);
    w[3] = rotl(w[3], 21);
    w[1] = w[1] ^ w[2];
    w[3] = w[3] ^ w[0];
    w[2] = rotl(w[2], 32);
    sip_round = w;
  endfunction

endpackage

FILE: rtl/mphl_ram.sv
// generic single-port ram with registered read
module mphl_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_o <= mem[addr_i];
  end

endmodule

FILE: rtl/mphl_sip.sv
// siphash-2-4 engine for two lanes, one round per cycle
module mphl_sip import mphl_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        init_i,
  input  logic [63:0] key_a_i,
  input  logic [63:0] key_b_i,
  input  logic [63:0] msg_i,
  input  logic        final_i,
  output logic        busy_o,
  output logic        done_o,
  output logic [63:0] h_a_o,
  output logic [63:0] h_b_o
);

  lane_t va_q, va_d, vb_q, vb_d;
  logic [2:0] cnt_q, cnt_d;
  logic busy_q, busy_d, fin_q, fin_d, done_q, done_d;
  logic [63:0] m_q, m_d;
  lane_t ra, rb;

  assign ra = sip_round(va_q);
  assign rb = sip_round(vb_q);

  always_comb begin
    va_d = va_q;
    vb_d = vb_q;
    cnt_d = cnt_q;
    busy_d = busy_q;
    fin_d = fin_q;
    m_d = m_q;
    done_d = 1'b0;
    if (start_i && !busy_q) begin
      if (init_i) begin
        va_d[0] = key_a_i ^ SipC0;
        va_d[1] = SipC1;
        va_d[2] = key_a_i ^ SipC2;
        va_d[3] = SipC3 ^ msg_i;
        vb_d[0] = key_b_i ^ SipC0;
        vb_d[1] = SipC1;
        vb_d[2] = key_b_i ^ SipC2;
        vb_d[3] = SipC3 ^ msg_i;
      end else begin
        va_d[3] = va_q[3] ^ msg_i;
        vb_d[3] = vb_q[3] ^ msg_i;
      end
      m_d = msg_i;
      fin_d = final_i;
      cnt_d = 3'd0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      va_d = ra;
      vb_d = rb;
      cnt_d = cnt_q + 3'd1;
      if (cnt_q == 3'd1) begin
        va_d[0] = ra[0] ^ m_q;
        vb_d[0] = rb[0] ^ m_q;
        if (fin_q) begin
          va_d[2] = ra[2] ^ {56'd0, FinalXor};
          vb_d[2] = rb[2] ^ {56'd0, FinalXor};
        end else begin
          busy_d = 1'b0;
          done_d = 1'b1;
        end
      end else if (cnt_q == 3'd5) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q <= '0;
      fin_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q <= cnt_d;
      fin_q <= fin_d;
    end
  end

  always_ff @(posedge clk_i) begin
    va_q <= va_d;
    vb_q <= vb_d;
    m_q <= m_d;
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign h_a_o = va_q[0] ^ va_q[1] ^ va_q[2] ^ va_q[3];
  assign h_b_o = vb_q[0] ^ vb_q[1] ^ vb_q[2] ^ vb_q[3];

endmodule

FILE: rtl/mphl_table.sv
// sorted node table: insert by shifting and probe search over two rams
module mphl_table import mphl_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        lookup_i,
  input  logic        clear_i,
  input  logic [63:0] h1_i,
  input  logic [63:0] h2_i,
  input  logic [7:0]  probes_i,
  output logic        idle_o,
  output logic        done_o,
  output result_t     res_o
);

  typedef enum logic [3:0] {
    StIdle, StSearch, StSrchWait, StSrchRd, StShiftRd, StShiftWait, StShiftWr,
    StPick, StPickWait, StProbeEval, StDone
  } state_e;

  state_e st_q;
  logic [TotW-1:0] total_q, lo_q, hi_q;
  logic lookup_q, done_q;
  logic [63:0] h1_q, h2_q, p_q, best_q, hold_q;
  logic [7:0] k_q, nprob_q;
  logic [NodeW-1:0] hold_n_q;
  logic [TotW-1:0] sh_q;
  result_t res_q;

  logic we;
  logic [IdxW-1:0] addr;
  logic [63:0] wpt, rpt;
  logic [NodeW-1:0] wnd, rnd;
  logic [TotW-1:0] mid, sum;
  logic [63:0] probe_gap;

  assign sum = lo_q + hi_q;
  assign mid = sum >> 1;
  assign probe_gap = rpt - p_q;

  always_comb begin
    we = 1'b0;
    addr = mid[IdxW-1:0];
    wpt = hold_q;
    wnd = hold_n_q;
    unique case (st_q)
      StShiftRd: addr = sh_q[IdxW-1:0] - IdxW'(1);
      StShiftWr: begin
        we = 1'b1;
        addr = sh_q[IdxW-1:0];
        if (sh_q == lo_q) begin
          wpt = h1_q;
          wnd = total_q[NodeW-1:0];
        end else begin
          wpt = hold_q;
          wnd = hold_n_q;
        end
      end
      StPick, StPickWait: addr = (lo_q >= total_q) ? '0 : lo_q[IdxW-1:0];
      default: addr = mid[IdxW-1:0];
    endcase
  end

  mphl_ram #(.Width(64), .Depth(MaxNodes)) u_pts (
    .clk_i, .we_i(we), .addr_i(addr), .wdata_i(wpt), .rdata_o(rpt)
  );
  mphl_ram #(.Width(NodeW), .Depth(MaxNodes)) u_nds (
    .clk_i, .we_i(we), .addr_i(addr), .wdata_i(wnd), .rdata_o(rnd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle;
      total_q <= '0;
      done_q <= 1'b0;
      lo_q <= '0;
      hi_q <= '0;
      sh_q <= '0;
      k_q <= '0;
      lookup_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (st_q)
        StIdle: begin
          if (clear_i) begin
            total_q <= '0;
          end else if (start_i) begin
            h1_q <= h1_i;
            h2_q <= h2_i;
            p_q <= h1_i;
            nprob_q <= probes_i;
            lookup_q <= lookup_i;
            k_q <= '0;
            lo_q <= '0;
            hi_q <= total_q;
            res_q.node <= '0;
            res_q.distance <= '0;
            if (lookup_i) begin
              res_q.kind <= KindLookup;
              res_q.distance <= AllOnes;
              if (total_q == '0) begin
                res_q.status <= StatEmpty;
                st_q <= StDone;
              end else if (probes_i == 8'd0) begin
                res_q.status <= StatNoProbe;
                st_q <= StDone;
              end else begin
                res_q.status <= StatOk;
                st_q <= StSearch;
              end
            end else begin
              res_q.kind <= KindStored;
              if (total_q >= TotW'(MaxNodes)) begin
                res_q.status <= StatFull;
                st_q <= StDone;
              end else begin
                res_q.status <= StatOk;
                st_q <= StSearch;
              end
            end
          end
        end
        StSearch: begin
          if (lo_q < hi_q) begin
            st_q <= StSrchWait;
          end else if (lookup_q) begin
            st_q <= StPick;
          end else begin
            sh_q <= total_q;
            st_q <= StShiftRd;
          end
        end
        StSrchWait: st_q <= StSrchRd;
        StSrchRd: begin
          if (rpt > p_q) begin
            hi_q <= mid;
          end else begin
            lo_q <= mid + TotW'(1);
          end
          st_q <= StSearch;
        end
        StShiftRd: st_q <= (sh_q == lo_q) ? StShiftWr : StShiftWait;
        StShiftWait: st_q <= StShiftWr;
        StShiftWr: begin
          if (sh_q == lo_q) begin
            res_q.node <= total_q[NodeW-1:0];
            total_q <= total_q + TotW'(1);
            st_q <= StDone;
          end else begin
            sh_q <= sh_q - TotW'(1);
            st_q <= StShiftRd;
          end
        end
        StPick: st_q <= StPickWait;
        StPickWait: st_q <= StProbeEval;
        StProbeEval: begin
          if (k_q == 8'd0 || probe_gap < best_q) begin
            best_q <= probe_gap;
            res_q.distance <= probe_gap;
            res_q.node <= rnd;
          end
          if (k_q + 8'd1 == nprob_q) begin
            st_q <= StDone;
          end else begin
            k_q <= k_q + 8'd1;
            p_q <= p_q + h2_q;
            lo_q <= '0;
            hi_q <= total_q;
            st_q <= StSearch;
          end
        end
        StDone: begin
          done_q <= 1'b1;
          st_q <= StIdle;
        end
        default: st_q <= StIdle;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    hold_q <= rpt;
    hold_n_q <= rnd;
  end

  assign idle_o = (st_q == StIdle);
  assign done_o = done_q;
  assign res_o = res_q;

`ifndef SYNTHESIS
  a_total_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    total_q <= TotW'(MaxNodes)) else $error("table count overflow");
  a_done_from_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> st_q == StIdle) else $error("done outside idle");
  a_write_shift: assert property (@(posedge clk_i) disable iff (!rst_ni)
    we |-> !lookup_q) else $error("table write during lookup");
`endif

endmodule

FILE: rtl/multi_probe_hash_node_lookup_top.sv
// Multi-probe consistent hash node lookup. One word at a time: a non-final
// name/key word runs two siphash rounds of both lanes, a final word runs
// two compression and four finalization rounds plus the table work; a final
// word with all eight bytes is hashed as a full block, then a second pass
// absorbs the length word. A node insert does a binary search, then moves
// entries up one at a time in the table ram; a lookup runs one binary search
// per probe, bounded by the single-port table ram that every binary-search
// step reads. Clear answers on the next cycle. A result waits in an output
// register; the next word is taken once the previous one is finished.
module multi_probe_hash_node_lookup_top import mphl_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,  // data_word, byte_count, zero fill
  input  logic        s_axis_tlast,  // last_word
  input  logic [1:0]  s_axis_tuser,  // func
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [79:0] m_axis_tdata,  // node_index, best_distance, status, fill
  output logic [1:0]  m_axis_tuser,  // answer_kind
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i
);

  logic [63:0] seed1_q, seed2_q;
  logic [7:0] probes_q, len_q, len_d;
  logic busy_q, kind_q, pend_q, wait_q, ovalid_q;
  result_t ores_q, tres;
  logic acc, sip_busy, sip_done, tab_idle, tab_done, sip_start, sip_init, sip_fin;
  logic [63:0] h1, h2, msg, tail;
  logic [1:0] func;
  logic [63:0] dword;
  logic [3:0] bc, cnt;
  logic lastw, full_blk;
  logic second_q;
  logic [63:0] msg2_q;
  logic sip2;

  assign func = s_axis_tuser;
  assign dword = s_axis_tdata[63:0];
  assign bc = s_axis_tdata[67:64];
  assign lastw = s_axis_tlast;
  assign cnt = (bc > 4'd8) ? 4'd8 : bc;
  assign full_blk = !lastw || cnt == 4'd8;
  assign tail = (cnt == 4'd0) ? 64'd0 : (dword & (AllOnes >> (7'd64 - {cnt, 3'b000})));

  assign s_axis_tready = !sip_busy && tab_idle && !pend_q && !wait_q && !ovalid_q &&
                         !second_q;
  assign acc = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o = 1'b1;

  always_comb begin
    len_d = busy_q ? len_q : 8'd0;
    len_d = full_blk ? len_d + 8'd8 : len_d + {4'd0, cnt};
  end
  assign msg = full_blk ? dword : ({len_d, 56'd0} | tail);

  // after a full last block, a second pass absorbs the length word
  assign sip2 = second_q && sip_done;
  assign sip_start = sip2 || (acc && (func == FuncName || func == FuncKey));
  assign sip_init = !sip2 && !busy_q;
  assign sip_fin = sip2 || !full_blk;

  mphl_sip u_sip (
    .clk_i, .rst_ni,
    .start_i(sip_start), .init_i(sip_init),
    .key_a_i((func == FuncKey) ? seed1_q : 64'd0),
    .key_b_i((func == FuncKey) ? seed2_q : 64'd0),
    .msg_i(sip2 ? msg2_q : msg), .final_i(sip_fin),
    .busy_o(sip_busy), .done_o(sip_done), .h_a_o(h1), .h_b_o(h2)
  );

  mphl_table u_tab (
    .clk_i, .rst_ni,
    .start_i(pend_q && sip_done), .lookup_i(kind_q),
    .clear_i(acc && func == FuncClear),
    .h1_i(h1), .h2_i(h2), .probes_i(probes_q),
    .idle_o(tab_idle), .done_o(tab_done), .res_o(tres)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed1_q <= '0;
      seed2_q <= '0;
      probes_q <= 8'd21;
      busy_q <= 1'b0;
      kind_q <= 1'b0;
      len_q <= '0;
      pend_q <= 1'b0;
      wait_q <= 1'b0;
      ovalid_q <= 1'b0;
      second_q <= 1'b0;
      msg2_q <= '0;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          CfgSeedFirst: seed1_q <= cfg_data_i;
          CfgSeedSecond: seed2_q <= cfg_data_i;
          CfgProbeCount: probes_q <= cfg_data_i[7:0];
          default: ;
        endcase
      end
      if (m_axis_tvalid && m_axis_tready) ovalid_q <= 1'b0;
      if (acc) begin
        if (func == FuncClear) begin
          busy_q <= 1'b0;
          len_q <= '0;
          ovalid_q <= 1'b1;
          ores_q <= '{kind: KindCleared, node: '0, distance: '0, status: StatOk};
        end else if (func == FuncName || func == FuncKey) begin
          if (!busy_q) kind_q <= (func == FuncKey);
          len_q <= len_d;
          busy_q <= !lastw;
          if (lastw && full_blk) begin
            second_q <= 1'b1;
            msg2_q <= {len_d, 56'd0};
          end else if (lastw) begin
            pend_q <= 1'b1;
          end
        end
      end
      if (sip2) begin
        second_q <= 1'b0;
        pend_q <= 1'b1;
      end
      if (pend_q && sip_done) begin
        pend_q <= 1'b0;
        wait_q <= 1'b1;
      end
      if (tab_done) begin
        wait_q <= 1'b0;
        ovalid_q <= 1'b1;
        ores_q <= tres;
      end
    end
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tuser = ores_q.kind;
  assign m_axis_tdata = {2'd0, ores_q.status, ores_q.distance, ores_q.node};

`ifndef SYNTHESIS
  a_no_accept_when_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovalid_q && !m_axis_tready |=> ovalid_q) else $error("result dropped");
  a_one_job: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pend_q && wait_q)) else $error("two jobs in flight");
  a_done_waits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tab_done |-> wait_q) else $error("table result without request");
`endif

endmodule
